[rtl/infix_integer_expression_evaluator_assert.svh]
// assertion macros shared by the rtl
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define IIEE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after its cause
`define IIEE_ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
		else $error(msg);
`else
`define IIEE_ASSERT(lbl, clk, rst_n, prop, msg)
`define IIEE_ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg)
`endif

`endif

[rtl/iiee_pkg.sv]
package iiee_pkg;

	// width of the result value port
	localparam int VALUE_W = 32;

	// character codes
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_EQ   = 8'h3D;

	// digit weight for number entry
	localparam int RADIX = 10;

	// operator waiting for its right operand
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_MUL  = 2'd1,
		PEND_DIV  = 2'd2
	} pend_t;

	// operator character that closes the current factor
	typedef enum logic [2:0] {
		OPK_MUL = 3'd0,
		OPK_DIV = 3'd1,
		OPK_ADD = 3'd2,
		OPK_SUB = 3'd3,
		OPK_EQ  = 3'd4
	} opk_t;

	// controller to datapath
	typedef struct packed {
		logic accept;  // latch closing operator
		logic digit;   // append digit to number
		logic start;   // load multiply / divide unit
		logic step;    // one iteration of the unit
		logic apply;   // fold factor into term / total
		logic emit;    // load output register, clear expression
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic unit_busy;  // pending multiply or divide needs the unit
		logic op_eq;      // latched operator is '='
		logic out_free;   // output register can take a request
	} dp_sts_t;

endpackage

[rtl/iiee_ctrl.sv]
module iiee_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  iiee_pkg::dp_sts_t  sts,
	output iiee_pkg::ctl_cmd_t cmd
);

	localparam int CW = $clog2(DATA_WIDTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            take;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid && (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take && sts.is_digit) begin
					cmd.digit = 1'b1;
				end else if (take && sts.is_op) begin
					cmd.accept = 1'b1;
					if (sts.unit_busy) begin
						cmd.start = 1'b1;
						cnt_d     = CW'(DATA_WIDTH - 1);
						state_d   = ST_RUN;
					end else begin
						state_d = ST_APPLY;
					end
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_APPLY;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = sts.op_eq ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[rtl/iiee_dp.sv]
module iiee_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [7:0]                         char_code,
	input  iiee_pkg::ctl_cmd_t                 cmd,
	output iiee_pkg::dp_sts_t                  sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [iiee_pkg::VALUE_W-1:0] value,
	output logic                               divide_by_zero
);

	localparam int DW = DATA_WIDTH;
	localparam int VW = iiee_pkg::VALUE_W;

	// expression state
	logic [DW-1:0]       total_q, prod_q, num_q;
	iiee_pkg::pend_t     pend_q;
	logic                neg_q, zdiv_q;
	iiee_pkg::opk_t      op_q;

	// multiply / divide unit
	logic [DW-1:0]       acc_q;
	logic [DW-1:0]       opa_q, opb_q;
	logic                mul_q, qneg_q, bzero_q;

	// output register
	logic                out_valid_q, dz_q;
	logic [VW-1:0]       value_q;

	logic                is_digit, is_op;
	iiee_pkg::opk_t      op_kind;
	logic [3:0]          digit_val;
	logic [DW-1:0]       num_next;
	logic [DW-1:0]       abs_a, abs_b;
	logic [DW:0]         rem_sh, diff;
	logic [DW-1:0]       unit_res, factor, term, sum;
	logic                pend_unit;
	logic [VW-1:0]       total_ext;

	// character decode
	always_comb begin
		is_digit = (char_code >= iiee_pkg::CH_ZERO) && (char_code <= iiee_pkg::CH_NINE);
		is_op    = 1'b1;
		op_kind  = iiee_pkg::OPK_ADD;
		priority if (char_code == iiee_pkg::CH_MUL) begin
			op_kind = iiee_pkg::OPK_MUL;
		end else if (char_code == iiee_pkg::CH_DIV) begin
			op_kind = iiee_pkg::OPK_DIV;
		end else if (char_code == iiee_pkg::CH_ADD) begin
			op_kind = iiee_pkg::OPK_ADD;
		end else if (char_code == iiee_pkg::CH_SUB) begin
			op_kind = iiee_pkg::OPK_SUB;
		end else if (char_code == iiee_pkg::CH_EQ) begin
			op_kind = iiee_pkg::OPK_EQ;
		end else begin
			is_op = 1'b0;
		end
	end

	// number entry: num * 10 + digit, digit codes keep their value in the low nibble
	assign digit_val = char_code[3:0];
	assign num_next  = num_q * DW'(iiee_pkg::RADIX) + DW'(digit_val);

	// operand magnitudes for the divider
	assign abs_a = prod_q[DW-1] ? (~prod_q + 1'b1) : prod_q;
	assign abs_b = num_q[DW-1] ? (~num_q + 1'b1) : num_q;

	// restoring divide step
	assign rem_sh = {acc_q, opa_q[DW-1]};
	assign diff   = rem_sh - {1'b0, opb_q};

	// unit result and factor combination
	assign pend_unit = (pend_q == iiee_pkg::PEND_MUL) || (pend_q == iiee_pkg::PEND_DIV);
	always_comb begin
		if (mul_q) begin
			unit_res = acc_q;
		end else if (bzero_q) begin
			unit_res = '0;
		end else begin
			unit_res = qneg_q ? (~opa_q + 1'b1) : opa_q;
		end
	end
	assign factor = pend_unit ? unit_res : num_q;
	assign term   = neg_q ? (~factor + 1'b1) : factor;
	assign sum    = total_q + term;

	// fit total to the 32-bit result port
	generate
		if (DW >= VW) begin : g_cut
			assign total_ext = total_q[VW-1:0];
		end else begin : g_sext
			assign total_ext = {{(VW-DW){total_q[DW-1]}}, total_q};
		end
	endgenerate

	// status to controller
	always_comb begin
		sts.is_digit  = is_digit;
		sts.is_op     = is_op;
		sts.unit_busy = pend_unit;
		sts.op_eq     = (op_q == iiee_pkg::OPK_EQ);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// expression state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			prod_q      <= '0;
			num_q       <= '0;
			pend_q      <= iiee_pkg::PEND_NONE;
			neg_q       <= 1'b0;
			zdiv_q      <= 1'b0;
			op_q        <= iiee_pkg::OPK_ADD;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.digit) begin
				num_q <= num_next;
			end
			if (cmd.accept) begin
				op_q <= op_kind;
			end
			if (cmd.apply) begin
				if (pend_q == iiee_pkg::PEND_DIV && bzero_q) begin
					zdiv_q <= 1'b1;
				end
				unique case (op_q)
					iiee_pkg::OPK_MUL: begin
						prod_q <= factor;
						num_q  <= '0;
						pend_q <= iiee_pkg::PEND_MUL;
					end
					iiee_pkg::OPK_DIV: begin
						prod_q <= factor;
						num_q  <= '0;
						pend_q <= iiee_pkg::PEND_DIV;
					end
					iiee_pkg::OPK_ADD, iiee_pkg::OPK_SUB: begin
						total_q <= sum;
						prod_q  <= '0;
						num_q   <= '0;
						pend_q  <= iiee_pkg::PEND_NONE;
						neg_q   <= (op_q == iiee_pkg::OPK_SUB);
					end
					iiee_pkg::OPK_EQ: begin
						total_q <= sum;
					end
					default: begin
						total_q <= total_q;
					end
				endcase
			end
			// hand the result over and start a fresh expression
			if (cmd.emit) begin
				total_q     <= '0;
				prod_q      <= '0;
				num_q       <= '0;
				pend_q      <= iiee_pkg::PEND_NONE;
				neg_q       <= 1'b0;
				zdiv_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= zdiv_q ? '0 : total_ext;
			dz_q    <= zdiv_q;
		end
	end

	// shift-add multiply / restoring divide, one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q  <= '0;
			mul_q  <= (pend_q == iiee_pkg::PEND_MUL);
			qneg_q <= prod_q[DW-1] ^ num_q[DW-1];
			bzero_q <= (num_q == '0);
			if (pend_q == iiee_pkg::PEND_MUL) begin
				opa_q <= prod_q;
				opb_q <= num_q;
			end else begin
				opa_q <= abs_a;
				opb_q <= abs_b;
			end
		end else if (cmd.step) begin
			if (mul_q) begin
				if (opb_q[0]) begin
					acc_q <= acc_q + opa_q;
				end
				opa_q <= {opa_q[DW-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[DW-1:1]};
			end else begin
				if (!diff[DW]) begin
					acc_q <= diff[DW-1:0];
				end else begin
					acc_q <= rem_sh[DW-1:0];
				end
				opa_q <= {opa_q[DW-2:0], !diff[DW]};
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign divide_by_zero = dz_q;

endmodule

[rtl/infix_integer_expression_evaluator.sv]
// Streaming evaluator for integer infix expressions.
// Input channel: one ASCII character per request on char_code (in_valid /
// in_stall). Digits build a number, '+' '-' '*' '/' combine terms with the
// usual precedence, '=' ends the expression; all other characters are dropped.
// Output channel: one request per '=' carrying value (32-bit signed) and
// divide_by_zero (out_valid / out_stall).
// Timing: a digit or ignored character is taken while idle. An operator goes
// through the APPLY state when no times or divide is pending; otherwise it
// first runs the shared one-bit-per-cycle multiply / divide unit in the RUN
// state. '=' goes on from APPLY to the EMIT state, which waits until the
// output register is free and then loads it.
// in_stall is high while an operator is being processed.
// Reset clears the expression and the output valid flag; no request is pending.
// While the receiver stalls, the result is held and input characters keep
// flowing; a following '=' waits until the held result has been taken.
`include "infix_integer_expression_evaluator_assert.svh"

module infix_integer_expression_evaluator #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          char_code,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [iiee_pkg::VALUE_W-1:0] value,
	output logic                                divide_by_zero
);

	iiee_pkg::ctl_cmd_t cmd;
	iiee_pkg::dp_sts_t  sts;

	// sequencer
	iiee_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// accumulators, arithmetic unit and output register
	iiee_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_code      (char_code),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.divide_by_zero (divide_by_zero)
	);

	// digit, step, apply and emit commands never overlap
	`IIEE_ASSERT(a_cmd_excl, clk, arst_n, $onehot0({cmd.digit, cmd.step, cmd.apply, cmd.emit}), "datapath commands overlap")
	// an emitted result is visible next cycle and is zero on a zero divisor
	`IIEE_ASSERT_NEXT(a_emit_out, clk, arst_n, cmd.emit, out_valid && (!divide_by_zero || value == '0), "emitted result missing or nonzero after divide by zero")
	// input is held off while the arithmetic unit runs
	`IIEE_ASSERT_NEXT(a_start_stall, clk, arst_n, cmd.start, in_stall, "input accepted while unit busy")

endmodule
